// ===== sv/spgc_pkg.sv =====
// Constants shared by the SPI panel GRAM controller: opcodes, event codes, word layouts.
// No dependencies; imported by spi_panel_gram_controller.
package spgc_pkg;

  // event kinds carried in tuser
  localparam logic [2:0] EV_SPI_BYTE = 3'd0;
  localparam logic [2:0] EV_CS_PIN   = 3'd1;
  localparam logic [2:0] EV_RST_PIN  = 3'd2;
  localparam logic [2:0] EV_PWR_PIN  = 3'd3;
  localparam logic [2:0] EV_PIX_READ = 3'd4;

  // panel command opcodes
  localparam logic [7:0] OP_SWRESET = 8'h01;
  localparam logic [7:0] OP_SLPIN   = 8'h10;
  localparam logic [7:0] OP_SLPOUT  = 8'h11;
  localparam logic [7:0] OP_INVOFF  = 8'h20;
  localparam logic [7:0] OP_INVON   = 8'h21;
  localparam logic [7:0] OP_DISPOFF = 8'h28;
  localparam logic [7:0] OP_DISPON  = 8'h29;
  localparam logic [7:0] OP_CASET   = 8'h2A;
  localparam logic [7:0] OP_RASET   = 8'h2B;
  localparam logic [7:0] OP_RAMWR   = 8'h2C;

  // origin used until a full visible-size RAMWR window is seen
  localparam logic [15:0] DEF_ORG_X = 16'd2;
  localparam logic [15:0] DEF_ORG_Y = 16'd1;

  localparam logic [15:0] INV_MASK = 16'hFFFF;

  localparam int RD_W        = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 56;

endpackage

// ===== sv/spi_panel_gram_controller.sv =====
// Pipeline: an accepted input word passes the input register, the registered store read, then the output reg.
// Throughput: one word per cycle absent backpressure or clearing; stage bubbles never stall intake.
// Reset: synchronous active-low rst_n restores all panel state, then a clearing pass walks the
// pixel store one entry per cycle (all STORE_WIDTH*STORE_HEIGHT entries, 25600 by default) with
// in_tready held low; the rate is set by the single write port of the pixel store.
// Depends on spgc_pkg.
module spi_panel_gram_controller #(
  parameter int STORE_WIDTH    = 160,
  parameter int STORE_HEIGHT   = 160,
  parameter int VISIBLE_WIDTH  = 128,
  parameter int VISIBLE_HEIGHT = 128,
  parameter int PARAM_LIMIT    = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] data_byte, [8] pin_level, [15:9] read_x, [22:16] read_y, [23] zero
  input  logic [spgc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] cmd, [3] dc_level
  input  logic [spgc_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] pixel_value, [16] display_lit, [48:17] frames_done, [55:49] zero
  output logic [spgc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import spgc_pkg::*;

  localparam int DEPTH = STORE_WIDTH * STORE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(STORE_WIDTH);
  localparam int RW    = $clog2(STORE_HEIGHT);
  localparam int PCW   = $clog2(PARAM_LIMIT + 1);
  localparam logic [15:0] VIS_W_M1 = 16'(VISIBLE_WIDTH - 1);
  localparam logic [15:0] VIS_H_M1 = 16'(VISIBLE_HEIGHT - 1);

  // ---------------- pipeline handshake ----------------
  logic in_v_r, s1_v_r, out_v_r;
  logic clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic out_free, s1_take, proc, in_fire;

  assign out_free  = !out_v_r || out_tready;
  assign s1_take   = !s1_v_r || out_free;
  assign proc      = in_v_r && s1_take;              // item in input reg commits its state
  assign in_tready = !clr_busy_r && (!in_v_r || s1_take);
  assign in_fire   = in_tvalid && in_tready;

  // ---------------- input register ----------------
  logic [2:0]      in_cmd_r;
  logic [7:0]      in_byte_r;
  logic            in_dc_r, in_lvl_r;
  logic [RD_W-1:0] in_rx_r, in_ry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_fire) begin
      in_v_r <= 1'b1;
    end else if (proc) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_cmd_r  <= in_tuser[2:0];
      in_dc_r   <= in_tuser[3];
      in_byte_r <= in_tdata[7:0];
      in_lvl_r  <= in_tdata[8];
      in_rx_r   <= in_tdata[15:9];
      in_ry_r   <= in_tdata[22:16];
    end
  end

  // ---------------- panel state ----------------
  logic chip_sel_r, rst_held_r, pwr_on_r, disp_en_r, sleep_r, inv_r;
  logic chip_sel_nxt, rst_held_nxt, pwr_on_nxt, disp_en_nxt, sleep_nxt, inv_nxt;
  logic [7:0] cur_cmd_r, cur_cmd_nxt;
  logic [7:0] par0_r, par1_r, par2_r, par0_nxt, par1_nxt, par2_nxt;
  logic [PCW-1:0] pcnt_r, pcnt_nxt;
  logic pix_wr_r, pix_wr_nxt;
  logic [15:0] col_start_r, col_end_r, row_start_r, row_end_r;
  logic [15:0] col_start_nxt, col_end_nxt, row_start_nxt, row_end_nxt;
  logic [15:0] col_cur_r, row_cur_r, col_cur_nxt, row_cur_nxt;
  logic [7:0] hi_byte_r, hi_byte_nxt;
  logic hi_v_r, hi_v_nxt;
  logic [15:0] org_x_r, org_y_r, org_x_nxt, org_y_nxt;
  logic org_known_r, org_known_nxt;
  logic [31:0] frame_cnt_r, frame_cnt_nxt;

  // store port signals from the event logic
  logic          item_we;
  logic [AW-1:0] item_wa;
  logic [15:0]   item_wd;
  logic [AW-1:0] rd_addr;
  logic          rd_hit, is_read;

  logic        win_vis, cur_in_store;
  logic [16:0] gx, gy;
  logic [15:0] org_x_use, org_y_use;

  // RAMWR window exactly the visible size
  assign win_vis = (col_end_r >= col_start_r) && (row_end_r >= row_start_r) &&
                   ((col_end_r - col_start_r) == VIS_W_M1) &&
                   ((row_end_r - row_start_r) == VIS_H_M1);

  assign cur_in_store = (col_cur_r < 16'(STORE_WIDTH)) && (row_cur_r < 16'(STORE_HEIGHT));

  assign org_x_use = org_known_r ? org_x_r : DEF_ORG_X;
  assign org_y_use = org_known_r ? org_y_r : DEF_ORG_Y;
  assign gx = {1'b0, org_x_use} + 17'(in_rx_r);
  assign gy = {1'b0, org_y_use} + 17'(in_ry_r);

  always_comb begin
    chip_sel_nxt  = chip_sel_r;
    rst_held_nxt  = rst_held_r;
    pwr_on_nxt    = pwr_on_r;
    disp_en_nxt   = disp_en_r;
    sleep_nxt     = sleep_r;
    inv_nxt       = inv_r;
    cur_cmd_nxt   = cur_cmd_r;
    par0_nxt      = par0_r;
    par1_nxt      = par1_r;
    par2_nxt      = par2_r;
    pcnt_nxt      = pcnt_r;
    pix_wr_nxt    = pix_wr_r;
    col_start_nxt = col_start_r;
    col_end_nxt   = col_end_r;
    row_start_nxt = row_start_r;
    row_end_nxt   = row_end_r;
    col_cur_nxt   = col_cur_r;
    row_cur_nxt   = row_cur_r;
    hi_byte_nxt   = hi_byte_r;
    hi_v_nxt      = hi_v_r;
    org_x_nxt     = org_x_r;
    org_y_nxt     = org_y_r;
    org_known_nxt = org_known_r;
    frame_cnt_nxt = frame_cnt_r;
    item_we       = 1'b0;
    item_wa       = AW'(row_cur_r[RW-1:0]) * AW'(STORE_WIDTH) + AW'(col_cur_r[CW-1:0]);
    item_wd       = {hi_byte_r, in_byte_r};
    rd_addr       = AW'(gy[RW-1:0]) * AW'(STORE_WIDTH) + AW'(gx[CW-1:0]);
    rd_hit        = 1'b0;
    is_read       = 1'b0;

    case (in_cmd_r)
      EV_SPI_BYTE: begin
        if (!rst_held_r && chip_sel_r) begin
          if (!in_dc_r) begin
            // command byte
            cur_cmd_nxt = in_byte_r;
            pcnt_nxt    = '0;
            pix_wr_nxt  = 1'b0;
            hi_v_nxt    = 1'b0;
            case (in_byte_r)
              OP_SWRESET: begin
                disp_en_nxt = 1'b0;
                sleep_nxt   = 1'b1;
              end
              OP_SLPOUT:  sleep_nxt   = 1'b0;
              OP_SLPIN:   sleep_nxt   = 1'b1;
              OP_DISPON:  disp_en_nxt = 1'b1;
              OP_DISPOFF: disp_en_nxt = 1'b0;
              OP_INVON:   inv_nxt     = 1'b1;
              OP_INVOFF:  inv_nxt     = 1'b0;
              OP_RAMWR: begin
                if (win_vis) begin
                  org_x_nxt     = col_start_r;
                  org_y_nxt     = row_start_r;
                  org_known_nxt = 1'b1;
                end
                col_cur_nxt = col_start_r;
                row_cur_nxt = row_start_r;
                pix_wr_nxt  = 1'b1;
              end
              default: ;
            endcase
          end else if (pix_wr_r) begin
            if (!hi_v_r) begin
              hi_byte_nxt = in_byte_r;
              hi_v_nxt    = 1'b1;
            end else begin
              // low byte completes a pixel; cursor walks the window
              hi_v_nxt = 1'b0;
              item_we  = cur_in_store;
              if (col_cur_r >= col_end_r) begin
                col_cur_nxt = col_start_r;
                if (row_cur_r >= row_end_r) begin
                  row_cur_nxt   = row_start_r;
                  frame_cnt_nxt = frame_cnt_r + 32'd1;
                end else begin
                  row_cur_nxt = row_cur_r + 16'd1;
                end
              end else begin
                col_cur_nxt = col_cur_r + 16'd1;
              end
            end
          end else if (pcnt_r < PCW'(PARAM_LIMIT)) begin
            pcnt_nxt = pcnt_r + PCW'(1);
            case (pcnt_r)
              PCW'(0): par0_nxt = in_byte_r;
              PCW'(1): par1_nxt = in_byte_r;
              PCW'(2): par2_nxt = in_byte_r;
              PCW'(3): begin
                // fourth parameter byte closes CASET / RASET
                if (cur_cmd_r == OP_CASET) begin
                  col_start_nxt = {par0_r, par1_r};
                  col_end_nxt   = {par2_r, in_byte_r};
                end else if (cur_cmd_r == OP_RASET) begin
                  row_start_nxt = {par0_r, par1_r};
                  row_end_nxt   = {par2_r, in_byte_r};
                end
              end
              default: ;
            endcase
          end
        end
      end
      EV_CS_PIN: begin
        if (chip_sel_r != in_lvl_r) begin
          chip_sel_nxt = in_lvl_r;
          if (in_lvl_r) begin
            hi_v_nxt = 1'b0;
          end
        end
      end
      EV_RST_PIN: begin
        if (rst_held_r != in_lvl_r) begin
          rst_held_nxt = in_lvl_r;
          if (in_lvl_r) begin
            disp_en_nxt = 1'b0;
            sleep_nxt   = 1'b1;
            pix_wr_nxt  = 1'b0;
            pcnt_nxt    = '0;
          end
        end
      end
      EV_PWR_PIN: pwr_on_nxt = in_lvl_r;
      EV_PIX_READ: begin
        is_read = 1'b1;
        rd_hit  = (gx < 17'(STORE_WIDTH)) && (gy < 17'(STORE_HEIGHT));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_sel_r  <= 1'b0;
      rst_held_r  <= 1'b0;
      pwr_on_r    <= 1'b1;
      disp_en_r   <= 1'b0;
      sleep_r     <= 1'b1;
      inv_r       <= 1'b0;
      cur_cmd_r   <= '0;
      par0_r      <= '0;
      par1_r      <= '0;
      par2_r      <= '0;
      pcnt_r      <= '0;
      pix_wr_r    <= 1'b0;
      col_start_r <= '0;
      col_end_r   <= 16'd127;
      row_start_r <= '0;
      row_end_r   <= 16'd127;
      col_cur_r   <= '0;
      row_cur_r   <= '0;
      hi_byte_r   <= '0;
      hi_v_r      <= 1'b0;
      org_x_r     <= '0;
      org_y_r     <= '0;
      org_known_r <= 1'b0;
      frame_cnt_r <= '0;
    end else if (proc) begin
      chip_sel_r  <= chip_sel_nxt;
      rst_held_r  <= rst_held_nxt;
      pwr_on_r    <= pwr_on_nxt;
      disp_en_r   <= disp_en_nxt;
      sleep_r     <= sleep_nxt;
      inv_r       <= inv_nxt;
      cur_cmd_r   <= cur_cmd_nxt;
      par0_r      <= par0_nxt;
      par1_r      <= par1_nxt;
      par2_r      <= par2_nxt;
      pcnt_r      <= pcnt_nxt;
      pix_wr_r    <= pix_wr_nxt;
      col_start_r <= col_start_nxt;
      col_end_r   <= col_end_nxt;
      row_start_r <= row_start_nxt;
      row_end_r   <= row_end_nxt;
      col_cur_r   <= col_cur_nxt;
      row_cur_r   <= row_cur_nxt;
      hi_byte_r   <= hi_byte_nxt;
      hi_v_r      <= hi_v_nxt;
      org_x_r     <= org_x_nxt;
      org_y_r     <= org_y_nxt;
      org_known_r <= org_known_nxt;
      frame_cnt_r <= frame_cnt_nxt;
    end
  end

  // ---------------- clearing pass after reset ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------- pixel store, one write and one registered read port ----------------
  logic [15:0]   gram [DEPTH];
  logic          pix_we;
  logic [AW-1:0] pix_wa;
  logic [15:0]   pix_wd;
  logic [15:0]   rd_data_r;

  assign pix_we = clr_busy_r || (proc && item_we);
  assign pix_wa = clr_busy_r ? clr_addr_r : item_wa;
  assign pix_wd = clr_busy_r ? 16'd0 : item_wd;

  always_ff @(posedge clk) begin
    if (pix_we) begin
      gram[pix_wa] <= pix_wd;
    end
    if (proc) begin
      rd_data_r <= gram[rd_addr];
    end
  end

  // ---------------- read stage ----------------
  logic        s1_isrd_r, s1_hit_r, s1_inv_r, s1_lit_r;
  logic [31:0] s1_frm_r;
  logic [15:0] s1_base, s1_pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_take) begin
      s1_v_r <= proc;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      s1_isrd_r <= is_read;
      s1_hit_r  <= rd_hit;
      s1_inv_r  <= inv_nxt;
      s1_lit_r  <= disp_en_nxt && !sleep_nxt && pwr_on_nxt;
      s1_frm_r  <= frame_cnt_nxt;
    end
  end

  // off-store reads take zero as the stored value; mask applies unless inversion is on
  assign s1_base = s1_hit_r ? rd_data_r : 16'd0;
  assign s1_pix  = !s1_isrd_r ? 16'd0 : (s1_inv_r ? s1_base : (s1_base ^ INV_MASK));

  // ---------------- output register ----------------
  logic [15:0] out_pix_r;
  logic        out_lit_r;
  logic [31:0] out_frm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_v_r) begin
      out_pix_r <= s1_pix;
      out_lit_r <= s1_lit_r;
      out_frm_r <= s1_frm_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_frm_r, out_lit_r, out_pix_r};

`ifndef SYNTHESIS
  a_no_intake_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready)
    else $error("input accepted during store clearing pass");

  a_pixel_write_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (!clr_busy_r && pix_we) |-> (pix_wr_r && hi_v_r && in_cmd_r == EV_SPI_BYTE && in_dc_r))
    else $error("pixel written without a completed byte pair");

  a_frame_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (frame_cnt_r == $past(frame_cnt_r) ||
              frame_cnt_r == $past(frame_cnt_r) + 32'd1))
    else $error("frame counter jumped");

  a_read_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_free) |=> s1_v_r)
    else $error("result lost in read stage under backpressure");
`endif

endmodule
